// ----- design/assert_macros.svh -----
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every edge outside reset
`define CHK_IMPLY(label, rst_n, clk, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("check failed");
// implication whose consequent is checked in the next cycle
`define CHK_NEXT(label, rst_n, clk, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("check failed");
`endif

// ----- design/lsm_pkg.sv -----
// shared types and constants of the latency statistics monitor
`timescale 1ns / 1ps
package lsm_pkg;
    localparam int CntW = 31;
    localparam int TimeW = 32;
    localparam int SumW = 64;
    localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_RECORD = 2'd2
    } op_t;

    // controller to datapath
    typedef struct packed {
        logic       latch_in;
        logic       update;
        logic       clear;
        logic       div_start;
        logic [1:0] div_sel;
        logic [1:0] div_store;
        logic       div_store_en;
    } lsm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic overflow;
    } lsm_stat_t;

    localparam logic [1:0] DivProc = 2'd0;
    localparam logic [1:0] DivDur = 2'd1;
    localparam logic [1:0] DivClass = 2'd2;
endpackage

// ----- design/lsm_divider.sv -----
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module lsm_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lsm_pkg::SumW-1:0]    dividend,
    input  logic [lsm_pkg::CntW-1:0]    divisor,
    output logic                        done,
    output logic [lsm_pkg::TimeW-1:0]   quotient
);
    import lsm_pkg::*;
    logic [SumW-1:0] quo_reg, quo_next;
    logic [CntW:0]   rem_reg, rem_next;
    logic [CntW-1:0] dvs_reg, dvs_next;
    logic [6:0]      cnt_reg, cnt_next;
    logic            busy_reg, busy_next, done_reg, done_next;
    logic [CntW+1:0] trial;

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg, quo_reg[SumW-1]} - {2'b00, dvs_reg};
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = 7'(SumW);
            busy_next = (divisor != '0);
            done_next = (divisor == '0);
            if (divisor == '0)
                quo_next = '0;
        end
        else if (busy_reg)
        begin
            if (!trial[CntW+1])
            begin
                rem_next = trial[CntW:0];
                quo_next = {quo_reg[SumW-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[CntW-1:0], quo_reg[SumW-1]};
                quo_next = {quo_reg[SumW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quotient = quo_reg[TimeW-1:0];
endmodule

// ----- design/lsm_datapath.sv -----
// statistics registers, class tables and result registers
`timescale 1ns / 1ps
module lsm_datapath #(
    parameter int NUM_CLASSES = 7
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lsm_pkg::lsm_cmd_t           cmd,
    output lsm_pkg::lsm_stat_t          stat,
    input  logic                        cfg_valid,
    input  logic [lsm_pkg::CntW-1:0]    cfg_data,
    input  logic [2:0]                  verb_class,
    input  logic                        succeeded,
    input  logic [lsm_pkg::TimeW-1:0]   processed_ms,
    input  logic [lsm_pkg::TimeW-1:0]   duration_ms,
    output logic [lsm_pkg::CntW-1:0]    request_total,
    output logic [lsm_pkg::CntW-1:0]    success_total,
    output logic [lsm_pkg::TimeW-1:0]   processed_average,
    output logic [lsm_pkg::TimeW-1:0]   processed_peak,
    output logic [lsm_pkg::TimeW-1:0]   duration_average,
    output logic [lsm_pkg::TimeW-1:0]   duration_peak,
    output logic [lsm_pkg::CntW-1:0]    class_count,
    output logic [lsm_pkg::TimeW-1:0]   class_minimum,
    output logic [lsm_pkg::TimeW-1:0]   class_maximum,
    output logic [lsm_pkg::TimeW-1:0]   class_average,
    output logic [lsm_pkg::CntW-1:0]    class_successes,
    output logic                        counted
);
    import lsm_pkg::*;
    localparam int ClsW = $clog2(NUM_CLASSES);

    logic [CntW-1:0]  skip_reg, req_reg, suc_reg;
    logic [SumW-1:0]  psum_reg, dsum_reg;
    logic [TimeW-1:0] pmax_reg, dmax_reg;
    logic [CntW-1:0]  ccnt_reg [NUM_CLASSES];
    logic [SumW-1:0]  csum_reg [NUM_CLASSES];
    logic [TimeW-1:0] cmin_reg [NUM_CLASSES];
    logic [TimeW-1:0] cmax_reg [NUM_CLASSES];
    logic [CntW-1:0]  csuc_reg [NUM_CLASSES];
    logic [ClsW-1:0]  cls_reg;
    logic             ok_reg, cnt_flag_reg;
    logic [TimeW-1:0] proc_reg, dur_reg;
    logic [TimeW-1:0] pavg_reg, davg_reg, cavg_reg;
    logic [CntW-1:0]  req_inc;
    logic [SumW-1:0]  div_a;
    logic [CntW-1:0]  div_b;
    logic             div_done;
    logic [TimeW-1:0] div_q;
    logic [ClsW-1:0]  cls_in;

    // out-of-range classes fold into the last one
    assign cls_in = ({2'b00, verb_class} >= 5'(NUM_CLASSES)) ? ClsW'(NUM_CLASSES - 1)
                                                           : ClsW'(verb_class);
    assign req_inc = req_reg + 1'b1;
    assign stat.overflow = (req_reg == CntMax);
    assign stat.div_done = div_done;

    always_comb
    begin
        case (cmd.div_sel)
            DivProc:
            begin
                div_a = psum_reg;
                div_b = req_reg;
            end
            DivDur:
            begin
                div_a = dsum_reg;
                div_b = req_reg;
            end
            default:
            begin
                div_a = csum_reg[cls_reg];
                div_b = ccnt_reg[cls_reg];
            end
        endcase
    end

    lsm_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(div_a),
        .divisor(div_b), .done(div_done), .quotient(div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg <= '0;
            req_reg <= '0;
            suc_reg <= '0;
            psum_reg <= '0;
            dsum_reg <= '0;
            pmax_reg <= '0;
            dmax_reg <= '0;
            cnt_flag_reg <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                ccnt_reg[i] <= '0;
                csum_reg[i] <= '0;
                cmin_reg[i] <= '0;
                cmax_reg[i] <= '0;
                csuc_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
                skip_reg <= cfg_data;
            if (cmd.clear)
            begin
                skip_reg <= '0;
                req_reg <= '0;
                suc_reg <= '0;
                psum_reg <= '0;
                dsum_reg <= '0;
                pmax_reg <= '0;
                dmax_reg <= '0;
                cnt_flag_reg <= 1'b0;
                for (int i = 0; i < NUM_CLASSES; i++)
                begin
                    ccnt_reg[i] <= '0;
                    csum_reg[i] <= '0;
                    cmin_reg[i] <= '0;
                    cmax_reg[i] <= '0;
                    csuc_reg[i] <= '0;
                end
            end
            else if (cmd.update)
            begin
                req_reg <= req_inc;
                psum_reg <= psum_reg + SumW'(proc_reg);
                dsum_reg <= dsum_reg + SumW'(dur_reg);
                if (pmax_reg < proc_reg)
                    pmax_reg <= proc_reg;
                if (dmax_reg < dur_reg)
                    dmax_reg <= dur_reg;
                cnt_flag_reg <= (req_inc > skip_reg);
                if (req_inc > skip_reg)
                begin
                    if (ok_reg)
                    begin
                        suc_reg <= suc_reg + 1'b1;
                        csuc_reg[cls_reg] <= csuc_reg[cls_reg] + 1'b1;
                    end
                    if (cmax_reg[cls_reg] < dur_reg)
                        cmax_reg[cls_reg] <= dur_reg;
                    if (!(ccnt_reg[cls_reg] != '0 && cmin_reg[cls_reg] < dur_reg))
                        cmin_reg[cls_reg] <= dur_reg;
                    ccnt_reg[cls_reg] <= ccnt_reg[cls_reg] + 1'b1;
                    csum_reg[cls_reg] <= csum_reg[cls_reg] + SumW'(dur_reg);
                end
            end
            else if (cmd.latch_in)
                cnt_flag_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            cls_reg <= cls_in;
            ok_reg <= succeeded;
            proc_reg <= processed_ms;
            dur_reg <= duration_ms;
        end
        if (cmd.div_store_en)
        begin
            case (cmd.div_store)
                DivProc: pavg_reg <= div_q;
                DivDur: davg_reg <= div_q;
                default: cavg_reg <= div_q;
            endcase
        end
    end

    assign request_total = req_reg;
    assign success_total = suc_reg;
    assign processed_average = pavg_reg;
    assign processed_peak = pmax_reg;
    assign duration_average = davg_reg;
    assign duration_peak = dmax_reg;
    assign class_count = ccnt_reg[cls_reg];
    assign class_minimum = cmin_reg[cls_reg];
    assign class_maximum = cmax_reg[cls_reg];
    assign class_average = cavg_reg;
    assign class_successes = csuc_reg[cls_reg];
    assign counted = cnt_flag_reg;
endmodule

// ----- design/lsm_controller.sv -----
// sequencing state machine of the monitor
`timescale 1ns / 1ps
module lsm_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    output logic               out_valid,
    input  logic               out_ready,
    output lsm_pkg::lsm_cmd_t  cmd,
    input  lsm_pkg::lsm_stat_t stat
);
    import lsm_pkg::*;
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_APPLY = 7'b0000010,
        ST_DIV0  = 7'b0000100,
        ST_DIV1  = 7'b0001000,
        ST_DIV2  = 7'b0010000,
        ST_OUT   = 7'b0100000,
        ST_WAIT  = 7'b1000000
    } state_t;
    state_t state_reg, state_next;
    op_t op_reg, op_next;

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    op_next = kind ? OP_CLEAR : OP_RECORD;
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (op_reg == OP_CLEAR || stat.overflow)
                    cmd.clear = 1'b1;
                else
                    cmd.update = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel = DivProc;
                state_next = ST_DIV0;
            end
            ST_DIV0:
            begin
                cmd.div_sel = DivDur;
                if (stat.div_done)
                begin
                    cmd.div_store_en = 1'b1;
                    cmd.div_store = DivProc;
                    cmd.div_start = 1'b1;
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                cmd.div_sel = DivClass;
                if (stat.div_done)
                begin
                    cmd.div_store_en = 1'b1;
                    cmd.div_store = DivDur;
                    cmd.div_start = 1'b1;
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2:
            begin
                cmd.div_sel = DivClass;
                if (stat.div_done)
                begin
                    cmd.div_store_en = 1'b1;
                    cmd.div_store = DivClass;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg <= OP_NONE;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
        end
    end
endmodule

// ----- design/latency_statistics_monitor.sv -----
// top level of the latency statistics monitor
`timescale 1ns / 1ps
// One request at a time: a request (record or clear) is taken, the statistics
// are updated in the next cycle, then the shared bit-serial divider forms the
// processing, duration and class averages one after another before the result
// is offered; the result stays on the outputs until taken and the next request
// is accepted in the following cycle at the earliest.
// A clear request, or a record that would overflow the 31-bit request count,
// zeroes all statistics and the skip threshold. The user must write the skip
// threshold through the cfg channel only while the block is idle; the block
// itself does not enforce this.
module latency_statistics_monitor #(
    parameter int NUM_CLASSES = 7
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lsm_pkg::CntW-1:0]    cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        kind,
    input  logic [2:0]                  verb_class,
    input  logic                        succeeded,
    input  logic [lsm_pkg::TimeW-1:0]   processed_ms,
    input  logic [lsm_pkg::TimeW-1:0]   duration_ms,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [lsm_pkg::CntW-1:0]    request_total,
    output logic [lsm_pkg::CntW-1:0]    success_total,
    output logic [lsm_pkg::TimeW-1:0]   processed_average,
    output logic [lsm_pkg::TimeW-1:0]   processed_peak,
    output logic [lsm_pkg::TimeW-1:0]   duration_average,
    output logic [lsm_pkg::TimeW-1:0]   duration_peak,
    output logic [lsm_pkg::CntW-1:0]    class_count,
    output logic [lsm_pkg::TimeW-1:0]   class_minimum,
    output logic [lsm_pkg::TimeW-1:0]   class_maximum,
    output logic [lsm_pkg::TimeW-1:0]   class_average,
    output logic [lsm_pkg::CntW-1:0]    class_successes,
    output logic                        counted
);
    import lsm_pkg::*;
    lsm_cmd_t  cmd;
    lsm_stat_t stat;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    lsm_controller u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .out_valid(out_valid), .out_ready(out_ready),
        .cmd(cmd), .stat(stat)
    );

    lsm_datapath #(.NUM_CLASSES(NUM_CLASSES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .cfg_valid(cfg_valid), .cfg_data(cfg_data),
        .verb_class(verb_class), .succeeded(succeeded),
        .processed_ms(processed_ms), .duration_ms(duration_ms),
        .request_total(request_total), .success_total(success_total),
        .processed_average(processed_average), .processed_peak(processed_peak),
        .duration_average(duration_average), .duration_peak(duration_peak),
        .class_count(class_count), .class_minimum(class_minimum),
        .class_maximum(class_maximum), .class_average(class_average),
        .class_successes(class_successes), .counted(counted)
    );
endmodule

// ----- design/lsm_checker.sv -----
// port-level checker of the monitor and its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lsm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [30:0] request_total,
    input logic [30:0] class_count,
    input logic        counted
);
    `CHK_IMPLY(a_no_overlap, rst_n, clk, out_valid, !in_ready)
    `CHK_NEXT(a_out_holds, rst_n, clk, out_valid && !out_ready, out_valid)
    `CHK_NEXT(a_busy_after_take, rst_n, clk, in_valid && in_ready, !in_ready)
    `CHK_IMPLY(a_counted_nonzero, rst_n, clk, out_valid && counted,
        class_count != 31'd0 && request_total != 31'd0)
endmodule

bind latency_statistics_monitor lsm_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .request_total(request_total), .class_count(class_count), .counted(counted)
);

// ----- tb/sv/tb_latency_statistics_monitor.sv -----
// testbench for the latency statistics monitor: directed and random requests checked against a predictor
`timescale 1ns / 1ps
module tb_latency_statistics_monitor;
    import lsm_pkg::*;

    localparam int NCLS = 7;
    localparam int IDLE_LIMIT = 20000;
    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    typedef struct {
        logic [CntW-1:0]  req_total;
        logic [CntW-1:0]  ok_total;
        logic [TimeW-1:0] proc_avg;
        logic [TimeW-1:0] proc_peak;
        logic [TimeW-1:0] dur_avg;
        logic [TimeW-1:0] dur_peak;
        logic [CntW-1:0]  cls_count;
        logic [TimeW-1:0] cls_min;
        logic [TimeW-1:0] cls_max;
        logic [TimeW-1:0] cls_avg;
        logic [CntW-1:0]  cls_ok;
        logic             was_counted;
    } stats_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CntW-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic kind = 1'b0;
    logic [2:0] verb_class = '0;
    logic succeeded = 1'b0;
    logic [TimeW-1:0] processed_ms = '0;
    logic [TimeW-1:0] duration_ms = '0;
    logic out_valid;
    logic out_ready = 1'b1;
    logic [CntW-1:0] request_total, success_total, class_count, class_successes;
    logic [TimeW-1:0] processed_average, processed_peak, duration_average, duration_peak;
    logic [TimeW-1:0] class_minimum, class_maximum, class_average;
    logic counted;

    // stall settings, in percent of cycles
    int unsigned send_idle = 0;
    int unsigned recv_stall = 0;
    int unsigned errors = 0;
    int unsigned idle_cycles = 0;

    // predictor state
    logic [CntW-1:0]  m_skip;
    logic [CntW-1:0]  m_requests;
    logic [CntW-1:0]  m_successes;
    logic [SumW-1:0]  m_proc_sum;
    logic [SumW-1:0]  m_dur_sum;
    logic [TimeW-1:0] m_proc_peak;
    logic [TimeW-1:0] m_dur_peak;
    logic [CntW-1:0]  m_cls_count [NCLS];
    logic [SumW-1:0]  m_cls_sum [NCLS];
    logic [TimeW-1:0] m_cls_min [NCLS];
    logic [TimeW-1:0] m_cls_max [NCLS];
    logic [CntW-1:0]  m_cls_ok [NCLS];

    stats_t pending_stats[$];

    latency_statistics_monitor #(.NUM_CLASSES(NCLS)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .verb_class(verb_class), .succeeded(succeeded),
        .processed_ms(processed_ms), .duration_ms(duration_ms),
        .out_valid(out_valid), .out_ready(out_ready),
        .request_total(request_total), .success_total(success_total),
        .processed_average(processed_average), .processed_peak(processed_peak),
        .duration_average(duration_average), .duration_peak(duration_peak),
        .class_count(class_count), .class_minimum(class_minimum),
        .class_maximum(class_maximum), .class_average(class_average),
        .class_successes(class_successes), .counted(counted)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // zero everything, skip threshold included
    task automatic wipe_stats();
        m_skip = '0;
        m_requests = '0;
        m_successes = '0;
        m_proc_sum = '0;
        m_dur_sum = '0;
        m_proc_peak = '0;
        m_dur_peak = '0;
        for (int i = 0; i < NCLS; i++)
        begin
            m_cls_count[i] = '0;
            m_cls_sum[i] = '0;
            m_cls_min[i] = '0;
            m_cls_max[i] = '0;
            m_cls_ok[i] = '0;
        end
    endtask

    function automatic logic [TimeW-1:0] mean(logic [SumW-1:0] total, logic [CntW-1:0] n);
        logic [SumW-1:0] q;
        if (n == 0)
            return '0;
        q = total / SumW'(n);
        return q[TimeW-1:0];
    endfunction

    // update the predicted statistics for one request and queue the result it should give
    task automatic predict_stats(logic k, logic [2:0] vc, logic ok, logic [TimeW-1:0] p,
                                 logic [TimeW-1:0] d);
        stats_t r;
        int c;
        c = (vc >= NCLS) ? NCLS - 1 : vc;
        r.was_counted = 1'b0;
        if (k == KIND_CLEAR || m_requests == CntMax)
            wipe_stats();
        else
        begin
            m_requests++;
            m_proc_sum += p;
            m_dur_sum += d;
            if (m_proc_peak < p) m_proc_peak = p;
            if (m_dur_peak < d) m_dur_peak = d;
            if (m_requests > m_skip)
            begin
                r.was_counted = 1'b1;
                if (ok) m_successes++;
                if (m_cls_max[c] < d) m_cls_max[c] = d;
                // first counted record, or a duration not above the minimum, sets the minimum
                if (!(m_cls_count[c] > 0 && m_cls_min[c] < d)) m_cls_min[c] = d;
                m_cls_count[c]++;
                m_cls_sum[c] += d;
                if (ok) m_cls_ok[c]++;
            end
        end
        r.req_total = m_requests;
        r.ok_total = m_successes;
        r.proc_avg = mean(m_proc_sum, m_requests);
        r.proc_peak = m_proc_peak;
        r.dur_avg = mean(m_dur_sum, m_requests);
        r.dur_peak = m_dur_peak;
        r.cls_count = m_cls_count[c];
        r.cls_min = m_cls_min[c];
        r.cls_max = m_cls_max[c];
        r.cls_avg = mean(m_cls_sum[c], m_cls_count[c]);
        r.cls_ok = m_cls_ok[c];
        pending_stats.push_back(r);
    endtask

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        errors++;
    endtask

    // result checker, sampled mid-cycle where all signals are settled
    always @(negedge clk)
    begin
        stats_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_stats.size() == 0)
            begin
                $display("unexpected result at %0t", $realtime);
                errors++;
            end
            else
            begin
                e = pending_stats.pop_front();
                if (request_total !== e.req_total)
                    report_mismatch("request_total", request_total, e.req_total);
                if (success_total !== e.ok_total)
                    report_mismatch("success_total", success_total, e.ok_total);
                if (processed_average !== e.proc_avg)
                    report_mismatch("processed_average", processed_average, e.proc_avg);
                if (processed_peak !== e.proc_peak)
                    report_mismatch("processed_peak", processed_peak, e.proc_peak);
                if (duration_average !== e.dur_avg)
                    report_mismatch("duration_average", duration_average, e.dur_avg);
                if (duration_peak !== e.dur_peak)
                    report_mismatch("duration_peak", duration_peak, e.dur_peak);
                if (class_count !== e.cls_count)
                    report_mismatch("class_count", class_count, e.cls_count);
                if (class_minimum !== e.cls_min)
                    report_mismatch("class_minimum", class_minimum, e.cls_min);
                if (class_maximum !== e.cls_max)
                    report_mismatch("class_maximum", class_maximum, e.cls_max);
                if (class_average !== e.cls_avg)
                    report_mismatch("class_average", class_average, e.cls_avg);
                if (class_successes !== e.cls_ok)
                    report_mismatch("class_successes", class_successes, e.cls_ok);
                if (counted !== e.was_counted)
                    report_mismatch("counted", counted, e.was_counted);
            end
        end
    end

    // watchdog: cycles without any handshake
    always @(negedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", pending_stats.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall);

    // send one request; called at a rising edge, returns at the edge it is taken or, when the sender idles, later
    task automatic send_request(logic k, logic [2:0] vc, logic ok, logic [TimeW-1:0] p,
                                logic [TimeW-1:0] d);
        in_valid <= 1'b1;
        kind <= k;
        verb_class <= vc;
        succeeded <= ok;
        processed_ms <= p;
        duration_ms <= d;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
        predict_stats(k, vc, ok, p, d);
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle)
                @(posedge clk);
        end
    endtask

    // sender holds off until every queued result is back and the block is idle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_skip(logic [CntW-1:0] v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        m_skip = v;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_record(logic [2:0] vc, logic ok, logic [TimeW-1:0] p,
                               logic [TimeW-1:0] d);
        send_request(KIND_RECORD, vc, ok, p, d);
    endtask

    function automatic logic [TimeW-1:0] pick_time();
        case ($urandom_range(3))
            0: return $urandom_range(1000);
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // extremes of the fields, every class including the out of range code, clear
    task automatic test_directed();
        write_skip('0);
        send_record(3'd0, 1'b1, '0, '0);
        send_record(3'd0, 1'b0, '1, '1);
        send_record(3'd0, 1'b1, 32'd5, 32'd7);
        for (int i = 0; i < 8; i++)
            send_record(3'(i), 1'(i), 32'(i * 100 + 3), 32'(1000 - i * 50));
        send_record(3'd7, 1'b1, '1, 32'd1);
        send_record(3'd6, 1'b1, 32'h8000_0000, 32'h5555_5555);
        send_record(3'd2, 1'b0, 32'haaaa_aaaa, 32'haaaa_aaaa);
        // clear with nonzero payload that must be ignored
        send_request(KIND_CLEAR, 3'd4, 1'b1, '1, '1);
        send_record(3'd4, 1'b1, 32'd9, 32'd9);
        send_request(KIND_CLEAR, 3'd7, 1'b0, '0, '0);
    endtask

    // records inside and beyond the skip threshold, both threshold extremes
    task automatic test_skip_threshold();
        write_skip(31'd3);
        for (int i = 0; i < 6; i++)
            send_record(3'(i % 3), 1'b1, 32'(i + 1), 32'(10 * i + 1));
        write_skip(CntMax);
        for (int i = 0; i < 4; i++)
            send_record(3'(i), 1'b1, pick_time(), pick_time());
        // clear also resets the threshold, so the next records count at once
        send_request(KIND_CLEAR, 3'd0, 1'b0, '0, '0);
        send_record(3'd1, 1'b1, 32'd4, 32'd4);
        send_record(3'd1, 1'b0, 32'd2, 32'd8);
    endtask

    task automatic run_random_phase(int unsigned n, int unsigned idle_pct,
                                    int unsigned stall_pct);
        drain_results();
        send_idle = idle_pct;
        recv_stall = stall_pct;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 3)
                send_request(KIND_CLEAR, 3'($urandom), 1'($urandom), $urandom, $urandom);
            else
                send_record(3'($urandom_range(7)), 1'($urandom), pick_time(), pick_time());
        end
    endtask

    task automatic test_random();
        run_random_phase(175, 0, 0);
        write_skip(31'($urandom_range(20)));
        run_random_phase(175, 56, 0);
        write_skip(31'($urandom));
        run_random_phase(40, 0, 56);
        write_skip('0);
        run_random_phase(135, 0, 56);
        write_skip(31'($urandom_range(40)));
        run_random_phase(175, 17, 17);
    endtask

    initial
    begin
        wipe_stats();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_skip_threshold();
        test_random();
        drain_results();
        repeat (300) @(posedge clk);
        if (errors == 0 && pending_stats.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+design
design/lsm_pkg.sv
design/lsm_divider.sv
design/lsm_datapath.sv
design/lsm_controller.sv
design/latency_statistics_monitor.sv
design/lsm_checker.sv
tb/sv/tb_latency_statistics_monitor.sv
